@@ sv/uart_tx_ring_with_rts_pause_core_macros.svh @@
// Assertion macros for the transmit ring RTL (used by uttx_back).
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef UART_TX_RING_WITH_RTS_PAUSE_CORE_MACROS_SVH
`define UART_TX_RING_WITH_RTS_PAUSE_CORE_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define UTTX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define UTTX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/uttx_pkg.sv @@
// Shared constants and types for the UART transmit ring.
// No dependencies; used by every module.
package uttx_pkg;

  localparam int RING_DEPTH = 128;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CMP_W      = ((PTR_W > 8) ? PTR_W : 8) + 1;

  // Input opcodes
  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_BYTE   = 2'd1;
  localparam logic [1:0] OP_EVENT  = 2'd2;
  localparam logic [1:0] OP_POLL   = 2'd3;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_BYTE,
    CMD_EVENT,
    CMD_POLL
  } cmd_kind_t;

  // Classified command passed from the front to the back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  frame_length;
    logic [7:0]  byte_value;
    logic        rts_busy;
    logic        len_over;
  } cmd_t;

  // Result fields held in the output register (the byte comes from the ring)
  typedef struct packed {
    logic        frame_accepted;
    logic        tx_valid;
    logic        irq_enabled;
    logic        tx_active;
    logic        busy_res;
    logic [6:0]  fill_level;
  } result_t;

endpackage

@@ sv/uttx_if.sv @@
// Valid/ready channel interfaces for items and results of the transmit ring.
// Depends on nothing; payload widths are fixed by the item format.
interface uttx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  frame_length;
  logic [7:0]  byte_value;
  logic        rts_busy;

  modport source (output valid, opcode, frame_length, byte_value, rts_busy, input ready);
  modport sink   (input valid, opcode, frame_length, byte_value, rts_busy, output ready);
endinterface

interface uttx_out_if;
  logic        valid;
  logic        ready;
  logic        frame_accepted;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        irq_enabled;
  logic        tx_active;
  logic        busy_res;
  logic [6:0]  fill_level;

  modport source (output valid, frame_accepted, tx_valid, tx_byte, irq_enabled,
                  tx_active, busy_res, fill_level, input ready);
  modport sink   (input valid, frame_accepted, tx_valid, tx_byte, irq_enabled,
                  tx_active, busy_res, fill_level, output ready);
endinterface

@@ sv/uttx_front.sv @@
// Front end: takes input transfers and classifies them into commands.
// Depends on uttx_pkg and uttx_in_if.
module uttx_front import uttx_pkg::*; (
  uttx_in_if.sink   in_ch,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  logic      cmd_ready
);

  // Pass the handshake straight to the queue
  assign cmd_valid   = in_ch.valid;
  assign in_ch.ready = cmd_ready;

  // Decode the opcode and keep only the fields each kind uses
  always_comb begin
    cmd              = '0;
    cmd.rts_busy     = in_ch.rts_busy;
    case (in_ch.opcode)
      OP_HEADER: begin
        cmd.kind         = CMD_HEADER;
        cmd.frame_length = in_ch.frame_length;
        cmd.len_over     = CMP_W'(in_ch.frame_length) > CMP_W'(RING_DEPTH - 1);
      end
      OP_BYTE: begin
        cmd.kind       = CMD_BYTE;
        cmd.byte_value = in_ch.byte_value;
      end
      OP_EVENT: cmd.kind = CMD_EVENT;
      OP_POLL:  cmd.kind = CMD_POLL;
      default:  cmd.kind = CMD_POLL;
    endcase
  end

endmodule

@@ sv/uttx_queue.sv @@
// Two-entry command queue between the front and the back.
// Depends on uttx_pkg.
module uttx_queue import uttx_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  wr_cmd,
  input  logic  wr_valid,
  output logic  wr_ready,
  output cmd_t  rd_cmd,
  output logic  rd_valid,
  input  logic  rd_ready
);

  cmd_t        entry_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        push;
  logic        pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_cmd   = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ sv/uttx_back.sv @@
// Back end: ring storage, frame admission, interrupt and RTS control, result register.
// Depends on uttx_pkg, uttx_out_if and the assertion macro header.
`include "uart_tx_ring_with_rts_pause_core_macros.svh"
module uttx_back import uttx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  uttx_out_if.source  out_ch
);

  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

  logic [7:0]       ring_mem [RING_DEPTH];
  logic [7:0]       rd_data_r;

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] fill_r, fill_nxt;
  logic             active_r, active_nxt;
  logic             irq_r, irq_nxt;
  logic             adm_r, adm_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic             out_valid_r;
  result_t          res_r, res_nxt;

  logic             exec;
  logic             wr_en;
  logic             rd_en;
  logic             admit;
  logic [CMP_W-1:0] free_space;
  logic [CMP_W-1:0] fill_ext;
  logic             fill_ok;

  // Execute one command per cycle whenever the result register can take it
  assign exec      = cmd_valid && (!out_valid_r || out_ch.ready);
  assign cmd_ready = exec;

  assign free_space = CMP_W'(RING_DEPTH - 1) - CMP_W'(fill_r);
  assign admit      = !cmd.len_over && (CMP_W'(cmd.frame_length) <= free_space);

  // Next state for the command at the head of the queue
  always_comb begin
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    fill_nxt   = fill_r;
    active_nxt = active_r;
    irq_nxt    = irq_r;
    adm_nxt    = adm_r;
    rem_nxt    = rem_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    res_nxt    = '0;
    case (cmd.kind)
      CMD_HEADER: begin
        res_nxt.frame_accepted = admit;
        if (admit) begin
          rem_nxt = cmd.frame_length;
          adm_nxt = (cmd.frame_length != 8'd0);
        end else begin
          rem_nxt = 8'd0;
          adm_nxt = 1'b0;
        end
      end
      CMD_BYTE: begin
        if (adm_r && (rem_r != 8'd0) && (fill_r != LAST_IDX)) begin
          wr_en    = 1'b1;
          wp_nxt   = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
          fill_nxt = fill_r + 1'b1;
          rem_nxt  = rem_r - 8'd1;
          // Last byte of the frame: start transmission if idle
          if (rem_r == 8'd1) begin
            adm_nxt = 1'b0;
            if (!active_r) begin
              active_nxt = 1'b1;
              irq_nxt    = 1'b1;
            end
          end
        end
      end
      CMD_EVENT: begin
        if (irq_r) begin
          if (fill_r == '0) begin
            irq_nxt    = 1'b0;
            active_nxt = 1'b0;
          end else if (cmd.rts_busy) begin
            irq_nxt = 1'b0;
          end else begin
            rd_en            = 1'b1;
            res_nxt.tx_valid = 1'b1;
            rp_nxt           = (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;
            fill_nxt         = fill_r - 1'b1;
          end
        end
      end
      CMD_POLL: begin
        if (active_r && !irq_r && !cmd.rts_busy) begin
          irq_nxt = 1'b1;
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
    fill_ext            = CMP_W'(fill_nxt);
    res_nxt.irq_enabled = irq_nxt;
    res_nxt.tx_active   = active_nxt;
    res_nxt.busy_res    = active_nxt || (fill_nxt != '0);
    res_nxt.fill_level  = fill_ext[6:0];
  end

  // Ring write and registered read
  always_ff @(posedge clk) begin
    if (exec && wr_en) begin
      ring_mem[wp_r] <= cmd.byte_value;
    end
    if (exec && rd_en) begin
      rd_data_r <= ring_mem[rp_r];
    end
  end

  // Hold control state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      fill_r      <= '0;
      active_r    <= 1'b0;
      irq_r       <= 1'b0;
      adm_r       <= 1'b0;
      rem_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec) begin
        wp_r     <= wp_nxt;
        rp_r     <= rp_nxt;
        fill_r   <= fill_nxt;
        active_r <= active_nxt;
        irq_r    <= irq_nxt;
        adm_r    <= adm_nxt;
        rem_r    <= rem_nxt;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_r <= res_nxt;
    end
  end

  // Drive the result channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_accepted = res_r.frame_accepted;
  assign out_ch.tx_valid       = res_r.tx_valid;
  assign out_ch.tx_byte        = res_r.tx_valid ? rd_data_r : 8'd0;
  assign out_ch.irq_enabled    = res_r.irq_enabled;
  assign out_ch.tx_active      = res_r.tx_active;
  assign out_ch.busy_res       = res_r.busy_res;
  assign out_ch.fill_level     = res_r.fill_level;

  // Fill count must agree with the distance between the pointers
  assign fill_ok = (wp_r >= rp_r) ? (fill_r == wp_r - rp_r)
                 : (CMP_W'(fill_r) == CMP_W'(wp_r) + CMP_W'(RING_DEPTH) - CMP_W'(rp_r));

  `UTTX_ASSERT_NOW(a_fill_matches_ptrs, 1'b1, fill_ok, "fill count disagrees with pointers")
  `UTTX_ASSERT_NOW(a_irq_needs_active, irq_r, active_r, "interrupt enabled while idle")
  `UTTX_ASSERT_NOW(a_admitted_has_bytes, adm_r, (rem_r != 8'd0), "admitted, no bytes left")
  `UTTX_ASSERT_NEXT(a_emit_shows_byte, (exec && rd_en), (out_valid_r && res_r.tx_valid), "no byte")

endmodule

@@ sv/uart_tx_ring_with_rts_pause_core.sv @@
// UART transmit ring with RTS pause: top level.
// Depends on uttx_pkg, uttx_if, uttx_front, uttx_queue and uttx_back.
//
// Usage:
//   in_ch carries one item per transfer: frame header, frame byte, TX-empty
//   event or poll tick, with the partner's RTS level. out_ch returns exactly
//   one result per item, in order: admission flag, the byte sent (if any),
//   interrupt enable, active flag, busy flag and ring fill level.
//   The ring has 128 cells and holds at most 127 waiting bytes.
// Pipeline:
//   An item passes through a queue entry and then the result register. The
//   single execute stage takes one item per cycle unless out_ch stalls, so
//   items may be sent back to back.
// Stall:
//   A two-entry queue sits between the front and back ends. While out_ch is
//   stalled the result register holds, the queue fills, and in_ch.ready
//   drops once both entries are taken.
// Reset:
//   rst_n (synchronous, active low) empties the ring and queue and clears all
//   flags; ring cells are not cleared and none is read before it is written.
module uart_tx_ring_with_rts_pause_core import uttx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  uttx_in_if.sink     in_ch,
  uttx_out_if.source  out_ch
);

  cmd_t  front_cmd;
  logic  front_valid;
  logic  front_ready;
  cmd_t  back_cmd;
  logic  back_valid;
  logic  back_ready;

  // Classify incoming items
  uttx_front u_front (
    .in_ch     (in_ch),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  // Decouple front and back
  uttx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cmd   (front_cmd),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_cmd   (back_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  // Execute commands against the ring
  uttx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .out_ch    (out_ch)
  );

endmodule

@@ dv/uttx_ring_checker.sv @@
// Result checker for the UART transmit ring: predicts each result from the items
// transferred in and compares it with what comes out. Depends on uttx_pkg and uttx_if.
module uttx_ring_checker import uttx_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  uttx_in_if    in_ch,
  uttx_out_if   out_ch,
  output int    error_count,
  output int    pending_count
);

  typedef struct packed {
    logic        frame_accepted;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_enabled;
    logic        tx_active;
    logic        busy_res;
    logic [6:0]  fill_level;
  } tx_result_t;

  // Shadow of the ring and its control flags
  logic [7:0]        ring_copy [RING_DEPTH];
  logic [PTR_W-1:0]  rd_idx;
  logic [PTR_W-1:0]  wr_idx;
  logic              active;
  logic              irq_on;
  logic              frame_open;
  logic [7:0]        bytes_left;

  tx_result_t  expected_results [$];
  int          mismatches = 0;

  // Apply one item to the shadow state and return the result it should produce
  function automatic tx_result_t predict_tx_result(cmd_kind_t kind, logic [7:0] len,
                                                   logic [7:0] data, logic rts);
    tx_result_t       res;
    logic [PTR_W-1:0] used;
    res = '0;
    used = wr_idx - rd_idx;
    case (kind)
      CMD_HEADER: begin
        if (int'(len) > (RING_DEPTH - 1) - int'(used)) begin
          frame_open = 1'b0;
          bytes_left = '0;
        end else begin
          res.frame_accepted = 1'b1;
          bytes_left = len;
          frame_open = (len != 0);
        end
      end
      CMD_BYTE: begin
        if (frame_open && bytes_left != 0 && int'(used) < RING_DEPTH - 1) begin
          ring_copy[wr_idx] = data;
          wr_idx = wr_idx + 1'b1;
          bytes_left = bytes_left - 1'b1;
          // last byte of the frame: start sending if idle
          if (bytes_left == 0) begin
            frame_open = 1'b0;
            if (!active) begin
              active = 1'b1;
              irq_on = 1'b1;
            end
          end
        end
      end
      CMD_EVENT: begin
        if (irq_on) begin
          if (rd_idx == wr_idx) begin
            irq_on = 1'b0;
            active = 1'b0;
          end else if (rts) begin
            irq_on = 1'b0;
          end else begin
            res.tx_valid = 1'b1;
            res.tx_byte = ring_copy[rd_idx];
            rd_idx = rd_idx + 1'b1;
          end
        end
      end
      default: begin
        if (active && !irq_on && !rts) irq_on = 1'b1;
      end
    endcase
    used = wr_idx - rd_idx;
    res.irq_enabled = irq_on;
    res.tx_active = active;
    res.busy_res = active || (used != 0);
    res.fill_level = 7'(used);
    return res;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Compare each result transfer, then record the expectation for each item transfer
  always @(posedge clk) begin : watch_channels
    tx_result_t want;
    if (!rst_n) begin
      rd_idx = '0;
      wr_idx = '0;
      active = 1'b0;
      irq_on = 1'b0;
      frame_open = 1'b0;
      bytes_left = '0;
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual fill %0h byte %0h",
                   $time, out_ch.fill_level, out_ch.tx_byte);
        end else begin
          want = expected_results.pop_front();
          check_field("frame_accepted", want.frame_accepted, out_ch.frame_accepted);
          check_field("tx_valid", want.tx_valid, out_ch.tx_valid);
          check_field("tx_byte", want.tx_byte, out_ch.tx_byte);
          check_field("irq_enabled", want.irq_enabled, out_ch.irq_enabled);
          check_field("tx_active", want.tx_active, out_ch.tx_active);
          check_field("busy_res", want.busy_res, out_ch.busy_res);
          check_field("fill_level", want.fill_level, out_ch.fill_level);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_tx_result(cmd_kind_t'(in_ch.opcode),
            in_ch.frame_length, in_ch.byte_value, in_ch.rts_busy));
    end
    error_count <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

@@ dv/tb_uart_tx_ring_with_rts_pause_core.sv @@
// Testbench top for the UART transmit ring: drives items and result backpressure,
// and gives the verdict. Depends on uttx_pkg, uttx_if, the core and uttx_ring_checker.
module tb_uart_tx_ring_with_rts_pause_core;
  import uttx_pkg::*;

  localparam int ITEM_TOTAL   = 1600;
  localparam int QUIET_FROM   = 1400;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 6;
  localparam int CYCLE_LIMIT  = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int items_sent = 0;
  bit idle_ok = 1'b1;
  bit hold_done = 1'b0;
  int cycle_count = 0;
  int error_count;
  int pending_count;

  uttx_in_if  in_ch ();
  uttx_out_if out_ch ();

  uart_tx_ring_with_rts_pause_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  uttx_ring_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_uart_tx_ring_with_rts_pause_core: errors");
      $finish;
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Offer one item and hold it until the transfer; unused fields carry noise
  task automatic send_item(cmd_kind_t kind, logic [7:0] value, logic rts);
    idle_ok = (items_sent < QUIET_FROM) && ((items_sent / 150) % 3 != 2);
    if (idle_ok && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= kind;
    in_ch.frame_length <= (kind == CMD_HEADER) ? value : 8'($urandom);
    in_ch.byte_value   <= (kind == CMD_BYTE) ? value : 8'($urandom);
    in_ch.rts_busy     <= rts;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Header followed by its bytes, with the odd event or poll mixed in
  task automatic send_frame();
    int pick;
    int len;
    int n_bytes;
    pick = $urandom_range(0, 19);
    if (pick < 12) len = $urandom_range(1, 12);
    else if (pick < 16) len = $urandom_range(13, 60);
    else if (pick < 18) len = $urandom_range(100, 127);
    else if (pick == 18) len = 0;
    else len = $urandom_range(128, 255);
    send_item(CMD_HEADER, 8'(len), coin());
    n_bytes = (len > RING_DEPTH - 1) ? $urandom_range(0, 3) : len;
    for (int k = 0; k < n_bytes; k++) begin
      // drop the rest of the frame now and then
      if ($urandom_range(0, 59) == 0) break;
      if ($urandom_range(0, 11) == 0)
        send_item(cmd_kind_t'($urandom_range(2, 3)), 8'($urandom), coin());
      send_item(CMD_BYTE, 8'($urandom), coin());
    end
  endtask

  // TX-empty events, with RTS pauses resumed by a poll
  task automatic drain_ring(int n);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        send_item(CMD_EVENT, 8'($urandom), 1'b1);
        if (coin()) send_item(CMD_POLL, 8'($urandom), 1'b1);
        send_item(CMD_POLL, 8'($urandom), 1'b0);
      end else begin
        send_item(CMD_EVENT, 8'($urandom), 1'b0);
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off to back up the input
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Item side: reset, directed cases, random traffic, then the verdict
  initial begin
    int pick;
    in_ch.valid = 1'b0;
    in_ch.opcode = CMD_HEADER;
    in_ch.frame_length = '0;
    in_ch.byte_value = '0;
    in_ch.rts_busy = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // event and poll while the interrupt is off, stray byte
    send_item(CMD_EVENT, 8'h00, 1'b0);
    send_item(CMD_POLL, 8'h00, 1'b0);
    send_item(CMD_BYTE, 8'hFF, 1'b1);
    // zero length frame, then a byte with no frame open
    send_item(CMD_HEADER, 8'd0, 1'b0);
    send_item(CMD_BYTE, 8'h5A, 1'b0);
    // oversized frames
    send_item(CMD_HEADER, 8'd255, 1'b1);
    send_item(CMD_HEADER, 8'd128, 1'b0);
    // frame cut short by a new header
    send_item(CMD_HEADER, 8'd3, 1'b0);
    send_item(CMD_BYTE, 8'h00, 1'b0);
    send_item(CMD_BYTE, 8'hFF, 1'b1);
    send_item(CMD_HEADER, 8'd2, 1'b1);
    send_item(CMD_BYTE, 8'hAA, 1'b0);
    send_item(CMD_BYTE, 8'h55, 1'b1);
    // RTS pause, ignored event, poll while busy, then resume
    send_item(CMD_EVENT, 8'h00, 1'b1);
    send_item(CMD_EVENT, 8'h00, 1'b0);
    send_item(CMD_POLL, 8'h00, 1'b1);
    send_item(CMD_POLL, 8'h00, 1'b0);
    // send all four bytes, then shut down on the empty ring
    repeat (5) send_item(CMD_EVENT, 8'hFF, 1'b0);
    // frame filling the whole ring
    send_item(CMD_HEADER, 8'd127, 1'b0);
    repeat (127) send_item(CMD_BYTE, 8'($urandom), coin());

    while (items_sent < ITEM_TOTAL) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) send_frame();
      else if (pick < 17) drain_ring($urandom_range(1, 40));
      else repeat ($urandom_range(1, 6))
        send_item(cmd_kind_t'($urandom_range(0, 3)), 8'($urandom), coin());
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_uart_tx_ring_with_rts_pause_core: clean");
    end else begin
      $display("tb_uart_tx_ring_with_rts_pause_core: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/uttx_pkg.sv
sv/uttx_if.sv
sv/uttx_front.sv
sv/uttx_queue.sv
sv/uttx_back.sv
sv/uart_tx_ring_with_rts_pause_core.sv
dv/uttx_ring_checker.sv
dv/tb_uart_tx_ring_with_rts_pause_core.sv
